### sv/rcfir_pkg.sv
// ----------------------------------------------------------------------------
// rcfir_pkg - shared types and constants of the real/complex FIR filter
// Holds the coefficient format, the tap index width, the stream codes and
// the control bundle that steers the row of tap cells.
// ----------------------------------------------------------------------------
package rcfir_pkg;

  // Coefficients are Q1.15 regardless of the sample width.
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned COEF_COUNT  = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int          ROUND_HALF  = 16384;

  localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sh7FFF;

  // Stream codes carried on the select input.
  localparam logic STREAM_REAL = 1'b0;
  localparam logic STREAM_CPLX = 1'b1;

  // Per-beat control seen by every tap cell.
  typedef struct packed {
    logic load;   // an input beat is accepted this cycle
    logic cplx;   // the beat belongs to the complex stream
  } cell_ctrl_t;

endpackage

### sv/rcfir_cell.sv
// ----------------------------------------------------------------------------
// rcfir_cell - one tap of the filter
// Holds one entry of each delay line, takes its neighbour's entry on every
// accepted beat and registers the product of the new entry with its tap.
// ----------------------------------------------------------------------------
module rcfir_cell
  import rcfir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cell_ctrl_t                            ctrl_i,
  input  logic signed [COEF_W-1:0]              coef_i,
  input  logic signed [SAMPLE_BITS-1:0]         real_i,
  input  logic signed [SAMPLE_BITS-1:0]         cre_i,
  input  logic signed [SAMPLE_BITS-1:0]         cim_i,
  output logic signed [SAMPLE_BITS-1:0]         real_o,
  output logic signed [SAMPLE_BITS-1:0]         cre_o,
  output logic signed [SAMPLE_BITS-1:0]         cim_o,
  output logic signed [SAMPLE_BITS+COEF_W-1:0]  prod_re_o,
  output logic signed [SAMPLE_BITS+COEF_W-1:0]  prod_im_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W;

  logic signed [SAMPLE_BITS-1:0] real_q, cre_q, cim_q;
  logic signed [SAMPLE_BITS-1:0] re_sel;
  logic signed [PROD_W-1:0]      mul_re, mul_im;
  logic signed [PROD_W-1:0]      prod_re_q, prod_im_q;

  // Only the line of the selected stream moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_q <= '0;
      cre_q  <= '0;
      cim_q  <= '0;
    end else if (ctrl_i.load) begin
      if (ctrl_i.cplx == STREAM_CPLX) begin
        cre_q <= cre_i;
        cim_q <= cim_i;
      end else begin
        real_q <= real_i;
      end
    end
  end

  assign re_sel = (ctrl_i.cplx == STREAM_CPLX) ? cre_i : real_i;
  assign mul_re = re_sel * coef_i;
  assign mul_im = cim_i * coef_i;

  // The imaginary product is forced to zero for real beats.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_re_q <= mul_re;
      prod_im_q <= (ctrl_i.cplx == STREAM_CPLX) ? mul_im : '0;
    end
  end

  assign real_o    = real_q;
  assign cre_o     = cre_q;
  assign cim_o     = cim_q;
  assign prod_re_o = prod_re_q;
  assign prod_im_o = prod_im_q;

endmodule

### sv/rcfir_sum.sv
// ----------------------------------------------------------------------------
// rcfir_sum - registered adder tree, rounding and saturation
// Adds the tap products of both parts in three registered levels, then rounds
// half up, drops the fraction and saturates into the output register.
// ----------------------------------------------------------------------------
module rcfir_sum
  import rcfir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_BITS+COEF_W-1:0]  prod_re_i [COEF_COUNT],
  input  logic signed [SAMPLE_BITS+COEF_W-1:0]  prod_im_i [COEF_COUNT],
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         out_re_o,
  output logic signed [SAMPLE_BITS-1:0]         out_im_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W;
  localparam int unsigned S1_W   = PROD_W + 1;
  localparam int unsigned S2_W   = PROD_W + 2;
  localparam int unsigned S3_W   = PROD_W + 3;
  localparam int unsigned RND_W  = S3_W + 1;
  localparam int unsigned SH_W   = RND_W - FRAC_BITS;
  localparam longint      SAT_HI_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint      SAT_LO_L = -SAT_HI_L - 1;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(SAT_HI_L);
  localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(SAT_LO_L);

  logic signed [PROD_W-1:0] prod [2][COEF_COUNT];
  logic signed [S1_W-1:0]   s1_q [2][4];
  logic signed [S2_W-1:0]   s2_q [2][2];
  logic signed [S3_W-1:0]   s3_q [2];
  logic signed [RND_W-1:0]  rnd  [2];
  logic signed [SH_W-1:0]   shr  [2];
  logic signed [SAMPLE_BITS-1:0] sat [2];
  logic signed [SAMPLE_BITS-1:0] out_q [2];

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  // A stage moves when it is empty or the stage behind it moves.
  assign eno = !vo_q || out_ready_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  always_comb begin
    for (int k = 0; k < COEF_COUNT; k++) begin
      prod[0][k] = prod_re_i[k];
      prod[1][k] = prod_im_i[k];
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      rnd[c] = RND_W'(s3_q[c]) + RND_W'(ROUND_HALF);
      shr[c] = SH_W'(rnd[c] >>> FRAC_BITS);
      if (shr[c] > SAT_HI) begin
        sat[c] = SAMPLE_BITS'(SAT_HI);
      end else if (shr[c] < SAT_LO) begin
        sat[c] = SAMPLE_BITS'(SAT_LO);
      end else begin
        sat[c] = SAMPLE_BITS'(shr[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      if (en1) begin
        for (int j = 0; j < 4; j++) begin
          s1_q[c][j] <= S1_W'(prod[c][2*j]) + S1_W'(prod[c][2*j+1]);
        end
      end
      if (en2) begin
        for (int j = 0; j < 2; j++) begin
          s2_q[c][j] <= S2_W'(s1_q[c][2*j]) + S2_W'(s1_q[c][2*j+1]);
        end
      end
      if (en3) s3_q[c] <= S3_W'(s2_q[c][0]) + S3_W'(s2_q[c][1]);
      if (eno) out_q[c] <= sat[c];
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = vo_q;
  assign out_re_o    = out_q[0];
  assign out_im_o    = out_q[1];

endmodule

### sv/fir_filter_real_and_complex_core.sv
// ----------------------------------------------------------------------------
// fir_filter_real_and_complex_core - FIR filter with real taps, two streams
// Direct-form FIR filter with eight programmable Q1.15 taps. A real stream
// and a complex stream keep separate delay lines; complex beats are filtered
// on both parts with the same taps.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   input   | in        | in_valid_i/in_ready_o | stream_sel_i, sample_re_i,
//           |           |                       | sample_im_i
//   output  | out       | out_valid_o/out_ready_i | out_re_o, out_im_o
//   config  | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One beat per clock is taken and delivered in steady state while the output
// is not stalled. The tap products are registered on the accepting edge
// itself; the beat then passes the registered levels of the adder tree and,
// rounded and saturated, enters the output register. Every stage holds its
// own beat, so a stalled output fills the pipeline before in_ready_o drops.
// Reset clears both delay lines and all valid bits and returns the taps to a
// near pass-through filter.
// ----------------------------------------------------------------------------
module fir_filter_real_and_complex_core
  import rcfir_pkg::*;
#(
  parameter int unsigned NUM_TAPS    = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COEF_W-1:0]             cfg_data_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          stream_sel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_re_o,
  output logic signed [SAMPLE_BITS-1:0] out_im_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W;

  // Tap registers. All eight are writable; only the first NUM_TAPS feed cells.
  logic signed [COEF_W-1:0] coef_q [COEF_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < COEF_COUNT; k++) begin
        coef_q[k] <= (k == 0) ? COEF0_RESET : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Handshake on the input side. The cells register their products on the
  // accepting edge, and the product stage is free whenever it is empty or the
  // adder tree takes its contents in the same cycle.
  logic       accept;
  logic       sum_ready;
  logic       prod_v_q;
  cell_ctrl_t ctrl;

  assign in_ready_o = !prod_v_q || sum_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign ctrl.load  = accept;
  assign ctrl.cplx  = stream_sel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (accept) begin
      prod_v_q <= 1'b1;
    end else if (sum_ready) begin
      prod_v_q <= 1'b0;
    end
  end

  // Row of tap cells. Cell zero takes the incoming sample; every further cell
  // takes the entry that its left neighbour holds, so the lines shift by one.
  logic signed [SAMPLE_BITS-1:0] real_line [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] cre_line  [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] cim_line  [NUM_TAPS];
  logic signed [PROD_W-1:0]      prod_re   [COEF_COUNT];
  logic signed [PROD_W-1:0]      prod_im   [COEF_COUNT];

  for (genvar k = 0; k < COEF_COUNT; k++) begin : g_tap
    if (k < NUM_TAPS) begin : g_used
      logic signed [SAMPLE_BITS-1:0] real_in, cre_in, cim_in;

      if (k == 0) begin : g_head
        assign real_in = sample_re_i;
        assign cre_in  = sample_re_i;
        assign cim_in  = sample_im_i;
      end else begin : g_body
        assign real_in = real_line[k-1];
        assign cre_in  = cre_line[k-1];
        assign cim_in  = cim_line[k-1];
      end

      rcfir_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_tap (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .coef_i    (coef_q[k]),
        .real_i    (real_in),
        .cre_i     (cre_in),
        .cim_i     (cim_in),
        .real_o    (real_line[k]),
        .cre_o     (cre_line[k]),
        .cim_o     (cim_line[k]),
        .prod_re_o (prod_re[k]),
        .prod_im_o (prod_im[k])
      );
    end else begin : g_unused
      // Leaves of the adder tree without a tap contribute nothing.
      assign prod_re[k] = '0;
      assign prod_im[k] = '0;
    end
  end

  // Adder tree, rounding, saturation and the output register.
  rcfir_sum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_v_q),
    .in_ready_o  (sum_ready),
    .prod_re_i   (prod_re),
    .prod_im_i   (prod_im),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

`ifndef SYNTHESIS
  // An empty product stage must never hold off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !prod_v_q |-> in_ready_o)
    else $error("input stalled with an empty product stage");

  // Every accepted beat occupies the product stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> prod_v_q)
    else $error("accepted beat lost before the adder tree");

  // A real beat yields no imaginary contribution from the first tap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (stream_sel_i == STREAM_REAL)) |=> (prod_im[0] == '0))
    else $error("real beat produced an imaginary product");
`endif

endmodule

### tb/rcfir_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcfir_checker - result predictor and comparator for the two-stream FIR
// Follows the tap writes and the accepted input beats, keeps its own taps and
// delay lines, and compares every accepted result beat with the oldest
// filtered value still waiting.
// ----------------------------------------------------------------------------
module rcfir_checker
  import rcfir_pkg::*;
#(
  parameter int unsigned NUM_TAPS    = 8,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COEF_W-1:0]             cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          stream_sel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_im_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] out_re_i,
  input  logic signed [SAMPLE_BITS-1:0] out_im_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int LINE_REAL    = 0;
  localparam int LINE_CPLX_RE = 1;
  localparam int LINE_CPLX_IM = 2;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t re;
    sample_t im;
  } filtered_t;

  logic signed [COEF_W-1:0] taps [COEF_COUNT];
  sample_t                  lines [3][NUM_TAPS];
  filtered_t                filtered_q [$];
  int                       fail_count;
  int                       pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // Shift a new sample in at the newest end of one delay line.
  task automatic push_sample(input int line_sel, input sample_t s);
    for (int k = NUM_TAPS - 1; k > 0; k--) lines[line_sel][k] = lines[line_sel][k-1];
    lines[line_sel][0] = s;
  endtask

  // Exact sum of products, rounded half up, scaled back to Q1.15 and saturated.
  function automatic sample_t fir_dot_q15(input int line_sel);
    longint acc;
    longint hi;
    longint lo;
    acc = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      acc += longint'(lines[line_sel][k]) * longint'(taps[k]);
    end
    acc = (acc + ROUND_HALF) >>> FRAC_BITS;
    hi  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo  = -hi - 1;
    if (acc > hi) acc = hi;
    else if (acc < lo) acc = lo;
    return sample_t'(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    filtered_t got;
    if (!rst_ni) begin
      for (int k = 0; k < COEF_COUNT; k++) taps[k] = '0;
      taps[0] = COEF0_RESET;
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < NUM_TAPS; k++) lines[l][k] = '0;
      end
      filtered_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < COEF_COUNT) taps[cfg_idx_i] = cfg_data_i;

      if (in_valid_i && in_ready_i) begin
        if (stream_sel_i == STREAM_REAL) begin
          push_sample(LINE_REAL, sample_re_i);
          want.re = fir_dot_q15(LINE_REAL);
          want.im = '0;
        end else begin
          push_sample(LINE_CPLX_RE, sample_re_i);
          push_sample(LINE_CPLX_IM, sample_im_i);
          want.re = fir_dot_q15(LINE_CPLX_RE);
          want.im = fir_dot_q15(LINE_CPLX_IM);
        end
        filtered_q.push_back(want);
      end

      if (out_valid_i && out_ready_i) begin
        got.re = out_re_i;
        got.im = out_im_i;
        if (filtered_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: result beat with none pending: re=%0d im=%0d",
                     $time, got.re, got.im);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (got.re !== want.re || got.im !== want.im) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                       $time, want.re, want.im, got.re, got.im);
            fail_count++;
          end
        end
      end
      pending = filtered_q.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the two-stream FIR filter core
// Drives directed and random sample beats on both streams through a series of
// tap settings, with bursty input and a stalling output, and takes the
// verdict from the failure and pending counts of the checker beside the core.
// ----------------------------------------------------------------------------
module tb_top;
  import rcfir_pkg::*;

  localparam int unsigned NUM_TAPS    = 8;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int CLK_HALF       = 10;
  // The longest stretch without any beat on either channel that a correct
  // run can show is the long receiver hold-off; the limit allows many times
  // its length.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  // Quiet time after the last result has come back, before a tap write or
  // the verdict.
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_ITEMS    = 115;
  localparam int PRESSURE_PHASE = 6;
  localparam int PRESSURE_ITEMS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = '0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Tap settings used by the random phases, in the order they are cycled.
  typedef enum int {
    TAPS_RANDOM,
    TAPS_SMALL,
    TAPS_SINGLE,
    TAPS_MAX,
    TAPS_MIN,
    TAPS_PASS,
    TAPS_KINDS
  } taps_kind_e;

  // Behaviour of the receiver over one span of cycles.
  typedef enum int {
    RX_FREE,
    RX_HALF,
    RX_SLOW,
    RX_PULSE
  } rx_mode_e;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx    = '0;
  logic [COEF_W-1:0]        cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     stream_sel = STREAM_REAL;
  sample_t                  sample_re  = '0;
  sample_t                  sample_im  = '0;
  logic                     out_ready  = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  sample_t                  out_re;
  sample_t                  out_im;
  int                       fail_count;
  int                       pending;

  logic signed [COEF_W-1:0] tap_set [COEF_COUNT];
  int                       burst_left = 0;
  bit                       no_gaps    = 1'b0;
  bit                       hold_req   = 1'b0;
  int                       idle_cycles = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  fir_filter_real_and_complex_core #(
    .NUM_TAPS    (NUM_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .stream_sel_i (stream_sel),
    .sample_re_i  (sample_re),
    .sample_im_i  (sample_im),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_re_o     (out_re),
    .out_im_o     (out_im)
  );

  rcfir_checker #(
    .NUM_TAPS    (NUM_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .stream_sel_i (stream_sel),
    .sample_re_i  (sample_re),
    .sample_im_i  (sample_im),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_re_i     (out_re),
    .out_im_i     (out_im),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The watchdog counts cycles in which neither channel moves a beat. Any
  // correct run keeps this count small, so reaching the limit means the core
  // has hung or lost beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver. It changes its behaviour every span of cycles: always ready,
  // ready half the time, ready rarely, or a regular on/off pulse. When the
  // stimulus raises hold_req it refuses every result for a long stretch,
  // counted here, so that the pipeline fills and the input side stalls.
  initial begin
    rx_mode_e mode;
    int       span;
    mode = RX_FREE;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req  = 1'b0;
        out_ready <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(RX_FREE, RX_PULSE));
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          RX_FREE:  out_ready <= 1'b1;
          RX_HALF:  out_ready <= ($urandom_range(0, 1) == 1);
          RX_SLOW:  out_ready <= ($urandom_range(0, 4) == 0);
          default:  out_ready <= ((span % 4) < 2);
        endcase
      end
    end
  end

  // Offer one beat and wait for the edge that takes it. The task returns at
  // the following falling edge with valid still high, so a beat that follows
  // straight away keeps valid up without a dip.
  task automatic send_beat(input logic sel, input sample_t re, input sample_t im);
    in_valid   <= 1'b1;
    stream_sel <= sel;
    sample_re  <= re;
    sample_im  <= im;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Send one beat as part of a burst. Between bursts the sender may drop
  // valid for a random gap; some bursts are long, and some follow without a gap.
  task automatic send_item(input logic sel, input sample_t re, input sample_t im);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 24);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    send_beat(sel, re, im);
  endtask

  // Stop offering beats and wait until every result has come back, then let
  // the pipeline settle.
  task automatic wait_idle;
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write all eight tap registers from tap_set on consecutive edges.
  task automatic write_taps;
    for (int k = 0; k < COEF_COUNT; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_COEF_0 + CFG_IDX_W'(k);
      cfg_data <= tap_set[k];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_taps(input taps_kind_e kind);
    int hot;
    hot = $urandom_range(0, COEF_COUNT - 1);
    for (int k = 0; k < COEF_COUNT; k++) begin
      case (kind)
        TAPS_RANDOM: tap_set[k] = COEF_W'($urandom);
        TAPS_SMALL:  tap_set[k] = COEF_W'($urandom_range(0, 8192) - 4096);
        TAPS_SINGLE: tap_set[k] = (k != hot) ? '0 :
                                  ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
        TAPS_MAX:    tap_set[k] = 16'sh7FFF;
        TAPS_MIN:    tap_set[k] = 16'sh8000;
        default:     tap_set[k] = (k == 0) ? COEF0_RESET : '0;
      endcase
    end
  endtask

  // Mostly full-range samples, with a good share of the extremes and of
  // small values so that rounding near zero is exercised as well.
  function automatic sample_t rand_sample;
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'($urandom_range(0, 511) - 256);
      3:       return $urandom_range(0, 1) ? '0 : '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic sel;
    // Reset is held from the start and released on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats under the taps left by reset, a near pass-through
    // filter: extremes of both parts, minus one and one, and real beats
    // with a non-zero imaginary part that must be ignored.
    send_item(STREAM_REAL, 16'sh7FFF, 16'sh0000);
    send_item(STREAM_REAL, 16'sh8000, 16'sh3039);
    send_item(STREAM_REAL, 16'sh0000, 16'shFFFF);
    send_item(STREAM_REAL, 16'shFFFF, 16'sh7FFF);
    send_item(STREAM_REAL, 16'sh0001, 16'sh8000);
    send_item(STREAM_CPLX, 16'sh7FFF, 16'sh8000);
    send_item(STREAM_CPLX, 16'sh8000, 16'sh7FFF);
    send_item(STREAM_CPLX, 16'shFFFF, 16'sh0001);
    send_item(STREAM_CPLX, 16'sh0000, 16'sh0000);

    // All taps at the positive limit: sums run far past the sample range,
    // high for the real stream and in both directions for the complex one.
    wait_idle();
    pick_taps(TAPS_MAX);
    write_taps();
    repeat (4) send_item(STREAM_REAL, 16'sh7FFF, 16'sh0000);
    repeat (3) send_item(STREAM_CPLX, 16'sh7FFF, 16'sh8000);

    // All taps at the negative limit, where the product of two negative
    // extremes saturates high.
    wait_idle();
    pick_taps(TAPS_MIN);
    write_taps();
    repeat (3) send_item(STREAM_CPLX, 16'sh8000, 16'sh8000);

    // A single half-weight tap puts the sum exactly halfway between two
    // outputs, so the rounding direction shows on odd samples.
    wait_idle();
    for (int k = 0; k < COEF_COUNT; k++) tap_set[k] = '0;
    tap_set[0] = 16'sh4000;
    write_taps();
    send_item(STREAM_REAL, 16'sh0001, 16'sh0000);
    send_item(STREAM_REAL, 16'shFFFF, 16'sh0000);
    send_item(STREAM_CPLX, 16'sh0003, 16'shFFFD);

    // Random phases. Each starts from an idle core with a new tap setting;
    // the stream select runs in stretches so that both delay lines build up
    // history between switches. In one phase the receiver holds off for a
    // long stretch while the sender keeps offering beats without a gap.
    sel = STREAM_REAL;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      pick_taps(taps_kind_e'(phase % TAPS_KINDS));
      write_taps();
      if (phase == PRESSURE_PHASE) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PRESSURE_ITEMS) no_gaps = 1'b0;
        if ($urandom_range(0, 2) == 0) sel = ~sel;
        send_item(sel, rand_sample(), rand_sample());
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
